// ===== rtl/xcr_pkg.sv =====
// Shared types and constants for the XMODEM checksum receiver.
package xcr_pkg;

    // Block geometry
    localparam int unsigned BLOCK_BYTES = 128;

    // Item action codes
    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;

    // Link control characters
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CAN = 8'h18;

    // Transfer status codes
    localparam logic [1:0] ST_RUN      = 2'd0;
    localparam logic [1:0] ST_DONE     = 2'd1;
    localparam logic [1:0] ST_NOSENDER = 2'd2;
    localparam logic [1:0] ST_ERROR    = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_HS_TIMEOUT   = 2'd0;
    localparam logic [1:0] REG_BYTE_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_NAK_RETRIES  = 2'd2;

    localparam int unsigned TICK_W = 20;
    localparam int unsigned CFG_W  = 20;

    // Configuration reset values
    localparam logic [TICK_W-1:0] HS_TIMEOUT_RST   = 20'h80000;
    localparam logic [TICK_W-1:0] BYTE_TIMEOUT_RST = 20'h20000;
    localparam logic [3:0]        NAK_RETRIES_RST  = 4'd6;

    typedef struct packed {
        logic [TICK_W-1:0] hs_timeout;
        logic [TICK_W-1:0] byte_timeout;
        logic [3:0]        nak_retries;
    } t_cfg;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       data_valid;
        logic [7:0] data_byte;
        logic [1:0] status;
    } t_result;

endpackage

// ===== rtl/xcr_in_if.sv =====
// Input item channel: action and received byte.
interface xcr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

// ===== rtl/xcr_out_if.sv =====
// Result item channel: control byte, payload byte and status.
interface xcr_out_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [1:0] status;

    modport source (output valid, output tx_valid, output tx_byte, output data_valid,
                    output data_byte, output status, input ready);
    modport sink   (input valid, input tx_valid, input tx_byte, input data_valid,
                    input data_byte, input status, output ready);
endinterface

// ===== rtl/xmodem_checksum_receiver.sv =====
// XMODEM checksum-mode receiver top level: config registers and result register.
// A result is in the output register in the cycle after its item is accepted.
// Throughput: one item per cycle while results are taken; the output register is reloaded in the cycle it drains.
// Reset (synchronous, active low): idle, expected block 1, output register empty,
// and the timeout and retry registers return to their default values.
module xmodem_checksum_receiver (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [xcr_pkg::CFG_W-1:0] i_cfg_data,
    xcr_in_if.sink                i_item,
    xcr_out_if.source             o_result
);
    import xcr_pkg::*;

    t_cfg    r_cfg;
    logic    r_out_valid;
    t_result r_out;
    logic    accept;
    logic    emit;
    t_result result;

    // Take a new item whenever the result register is free or draining
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign accept       = i_item.valid && i_item.ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hs_timeout   <= HS_TIMEOUT_RST;
            r_cfg.byte_timeout <= BYTE_TIMEOUT_RST;
            r_cfg.nak_retries  <= NAK_RETRIES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_HS_TIMEOUT:   r_cfg.hs_timeout   <= i_cfg_data[TICK_W-1:0];
                REG_BYTE_TIMEOUT: r_cfg.byte_timeout <= i_cfg_data[TICK_W-1:0];
                REG_NAK_RETRIES:  r_cfg.nak_retries  <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    xcr_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_action  (i_item.action),
        .i_rx_byte (i_item.rx_byte),
        .i_cfg     (r_cfg),
        .o_emit    (emit),
        .o_result  (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_out_valid <= accept && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out <= result;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.tx_valid   = r_out.tx_valid;
    assign o_result.tx_byte    = r_out.tx_byte;
    assign o_result.data_valid = r_out.data_valid;
    assign o_result.data_byte  = r_out.data_byte;
    assign o_result.status     = r_out.status;

endmodule

// ===== rtl/xcr_engine.sv =====
// Protocol state machine: per-item state update and result generation.
module xcr_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [1:0]       i_action,
    input  logic [7:0]       i_rx_byte,
    input  xcr_pkg::t_cfg    i_cfg,
    output logic             o_emit,
    output xcr_pkg::t_result o_result
);
    import xcr_pkg::*;

    // Phase codes
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_HAND = 3'd1;
    localparam logic [2:0] PH_SEQ  = 3'd2;
    localparam logic [2:0] PH_CMPL = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_SUM  = 3'd5;
    localparam logic [2:0] PH_NEXT = 3'd6;

    localparam logic [7:0] BLOCK_LOAD = 8'(BLOCK_BYTES);

    logic [2:0]        r_phase,     n_phase;
    logic [7:0]        r_exp_blk,   n_exp_blk;
    logic [7:0]        r_left,      n_left;
    logic [7:0]        r_sum,       n_sum;
    logic [TICK_W-1:0] r_wait,      n_wait;
    logic [3:0]        r_retries,   n_retries;
    logic [7:0]        data_sum;
    logic [7:0]        left_dec;
    t_result           res;

    assign data_sum = r_sum + i_rx_byte;
    assign left_dec = (r_left != 8'd0) ? (r_left - 8'd1) : 8'd0;

    // Next state and result for the item at the port
    always_comb begin
        n_phase   = r_phase;
        n_exp_blk = r_exp_blk;
        n_left    = r_left;
        n_sum     = r_sum;
        n_wait    = r_wait;
        n_retries = r_retries;
        res       = '0;

        case (i_action)
            ACT_START: begin
                n_phase      = PH_HAND;
                n_exp_blk    = 8'd1;
                n_left       = 8'd0;
                n_sum        = 8'd0;
                n_retries    = i_cfg.nak_retries;
                n_wait       = i_cfg.hs_timeout;
                res.tx_valid = 1'b1;
                res.tx_byte  = CH_NAK;
            end
            ACT_TICK: begin
                if (r_phase != PH_IDLE) begin
                    if (r_wait > TICK_W'(1)) begin
                        n_wait = r_wait - TICK_W'(1);
                    end else begin
                        // timeout fires
                        n_wait       = '0;
                        res.tx_valid = 1'b1;
                        if (r_phase == PH_HAND && r_retries != 4'd0) begin
                            n_retries   = r_retries - 4'd1;
                            n_wait      = i_cfg.hs_timeout;
                            res.tx_byte = CH_NAK;
                        end else begin
                            n_phase     = PH_IDLE;
                            res.tx_byte = CH_CAN;
                            res.status  = (r_phase == PH_HAND) ? ST_NOSENDER : ST_ERROR;
                        end
                    end
                end
            end
            ACT_BYTE: begin
                if (r_phase != PH_IDLE) begin
                    n_wait = i_cfg.byte_timeout;
                    // default outcome of a bad byte; good bytes override
                    res.tx_valid = 1'b1;
                    res.tx_byte  = CH_CAN;
                    res.status   = ST_ERROR;
                    n_phase      = PH_IDLE;
                    case (r_phase)
                        PH_HAND: begin
                            if (i_rx_byte == CH_SOH) begin
                                n_phase = PH_SEQ;
                                res     = '0;
                            end
                        end
                        PH_SEQ: begin
                            if (i_rx_byte == r_exp_blk) begin
                                n_phase = PH_CMPL;
                                res     = '0;
                            end
                        end
                        PH_CMPL: begin
                            if (8'(i_rx_byte + r_exp_blk) == 8'hff) begin
                                n_phase = PH_DATA;
                                n_left  = BLOCK_LOAD;
                                n_sum   = 8'd0;
                                res     = '0;
                            end
                        end
                        PH_DATA: begin
                            n_sum          = data_sum;
                            n_left         = left_dec;
                            n_phase        = (left_dec == 8'd0) ? PH_SUM : PH_DATA;
                            res            = '0;
                            res.data_valid = 1'b1;
                            res.data_byte  = i_rx_byte;
                        end
                        PH_SUM: begin
                            if (i_rx_byte == r_sum) begin
                                n_phase    = PH_NEXT;
                                n_exp_blk  = r_exp_blk + 8'd1;
                                res.tx_byte = CH_ACK;
                                res.status  = ST_RUN;
                            end
                        end
                        PH_NEXT: begin
                            if (i_rx_byte == CH_SOH) begin
                                n_phase = PH_SEQ;
                                res     = '0;
                            end else if (i_rx_byte == CH_EOT) begin
                                res.tx_byte = CH_ACK;
                                res.status  = ST_DONE;
                            end
                        end
                        default: begin
                            res = '0;
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result = res;
    assign o_emit   = res.tx_valid | res.data_valid | (res.status != ST_RUN);

    // State registers advance once per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_exp_blk <= 8'd1;
            r_left    <= 8'd0;
            r_sum     <= 8'd0;
            r_wait    <= '0;
            r_retries <= 4'd0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_exp_blk <= n_exp_blk;
            r_left    <= n_left;
            r_sum     <= n_sum;
            r_wait    <= n_wait;
            r_retries <= n_retries;
        end
    end

endmodule

// ===== dv/tb_xmodem_checksum_receiver.sv =====
// Self-checking testbench for the XMODEM checksum receiver: directed rows, then random transfers.
module tb_xmodem_checksum_receiver;
    import xcr_pkg::*;

    // Unused action code, the block must ignore it
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int PHASE_ITEMS = 20;
    localparam int SHOWN_ERRORS = 10;

    typedef enum logic [2:0] {
        RX_IDLE, RX_HAND, RX_SEQ, RX_CMPL, RX_DATA, RX_SUM, RX_NEXT
    } t_rx_phase;
    typedef enum {CHK_MODEL, CHK_NONE, CHK_GIVEN} t_chk;
    typedef enum {ROW_ITEM, ROW_CFG} t_row;

    typedef struct {
        t_row             kind;
        logic [1:0]       sel;    // action for items, register index for writes
        logic [CFG_W-1:0] val;    // received byte for items, write data for writes
        t_chk             chk;
        t_result          want;
    } t_dir_row;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [1:0]       cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    xcr_in_if  item_if ();
    xcr_out_if res_if ();

    xmodem_checksum_receiver u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (item_if),
        .o_result   (res_if)
    );

    bit       steady;       // no idling on either side while set
    int       errors;
    int       live_items;   // items the receiver acted on
    t_result  pending_out[$];
    t_dir_row dir_rows[$];

    // Configuration copy, as written to the block
    logic [TICK_W-1:0] cfg_hs      = HS_TIMEOUT_RST;
    logic [TICK_W-1:0] cfg_byte    = BYTE_TIMEOUT_RST;
    logic [3:0]        cfg_retries = NAK_RETRIES_RST;

    // Receiver state as predicted
    t_rx_phase         rx_ph    = RX_IDLE;
    logic [7:0]        rx_blk   = 8'd1;
    logic [7:0]        rx_left  = 8'd0;
    logic [7:0]        rx_sum   = 8'd0;
    logic [TICK_W-1:0] rx_wait  = '0;
    logic [3:0]        rx_tries = 4'd0;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic t_result ctl(input logic [7:0] c, input logic [1:0] st);
        t_result r;
        r = '0;
        r.tx_valid = 1'b1;
        r.tx_byte  = c;
        r.status   = st;
        return r;
    endfunction

    // Advance the receiver by one item; returns 1 when the item yields a result
    function automatic bit xmodem_step(input logic [1:0] act, input logic [7:0] b,
                                       output t_result r);
        bit bad;
        r = '0;
        bad = 1'b0;
        if (act == ACT_START) begin
            rx_ph    = RX_HAND;
            rx_blk   = 8'd1;
            rx_left  = 8'd0;
            rx_sum   = 8'd0;
            rx_tries = cfg_retries;
            rx_wait  = cfg_hs;
            r = ctl(CH_NAK, ST_RUN);
            return 1'b1;
        end
        if (act == ACT_NONE || rx_ph == RX_IDLE)
            return 1'b0;

        // Timer tick: count down, fire on the tick that reaches zero
        if (act == ACT_TICK) begin
            if (rx_wait > 1) begin
                rx_wait--;
                return 1'b0;
            end
            rx_wait = '0;
            if (rx_ph == RX_HAND && rx_tries != 0) begin
                rx_tries--;
                rx_wait = cfg_hs;
                r = ctl(CH_NAK, ST_RUN);
                return 1'b1;
            end
            r = ctl(CH_CAN, (rx_ph == RX_HAND) ? ST_NOSENDER : ST_ERROR);
            rx_ph = RX_IDLE;
            return 1'b1;
        end

        // Received byte
        rx_wait = cfg_byte;
        case (rx_ph)
            RX_HAND: begin
                if (b == CH_SOH) rx_ph = RX_SEQ;
                else bad = 1'b1;
            end
            RX_SEQ: begin
                if (b == rx_blk) rx_ph = RX_CMPL;
                else bad = 1'b1;
            end
            RX_CMPL: begin
                if (8'(b + rx_blk) == 8'hff) begin
                    rx_ph   = RX_DATA;
                    rx_left = 8'(BLOCK_BYTES);
                    rx_sum  = 8'd0;
                end else begin
                    bad = 1'b1;
                end
            end
            RX_DATA: begin
                rx_sum = rx_sum + b;
                if (rx_left != 0) rx_left--;
                if (rx_left == 0) rx_ph = RX_SUM;
                r.data_valid = 1'b1;
                r.data_byte  = b;
                return 1'b1;
            end
            RX_SUM: begin
                if (b != rx_sum) begin
                    bad = 1'b1;
                end else begin
                    rx_ph  = RX_NEXT;
                    rx_blk = rx_blk + 8'd1;
                    r = ctl(CH_ACK, ST_RUN);
                    return 1'b1;
                end
            end
            RX_NEXT: begin
                if (b == CH_SOH) begin
                    rx_ph = RX_SEQ;
                end else if (b == CH_EOT) begin
                    rx_ph = RX_IDLE;
                    r = ctl(CH_ACK, ST_DONE);
                    return 1'b1;
                end else begin
                    bad = 1'b1;
                end
            end
            default: rx_ph = RX_IDLE;
        endcase
        if (bad) begin
            rx_ph = RX_IDLE;
            r = ctl(CH_CAN, ST_ERROR);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Offer one item, wait for the handshake, then record what it should produce
    task automatic send_item(input logic [1:0] act, input logic [7:0] b,
                             input t_chk chk, input t_result want);
        t_result r;
        bit      has;
        while (!steady && $urandom_range(0, 99) < 6) begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid   <= 1'b1;
        item_if.action  <= act;
        item_if.rx_byte <= b;
        @(posedge clk);
        while (!item_if.ready) @(posedge clk);
        if (act == ACT_START || (act != ACT_NONE && rx_ph != RX_IDLE))
            live_items++;
        has = xmodem_step(act, b, r);
        case (chk)
            CHK_GIVEN: pending_out.push_back(want);
            CHK_MODEL: if (has) pending_out.push_back(r);
            default: ;
        endcase
    endtask

    task automatic feed(input logic [1:0] act, input logic [7:0] b);
        send_item(act, b, CHK_MODEL, '0);
    endtask

    // Register write once every result is out and the pipeline has settled
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        item_if.valid <= 1'b0;
        while (pending_out.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_HS_TIMEOUT:   cfg_hs = val[TICK_W-1:0];
            REG_BYTE_TIMEOUT: cfg_byte = val[TICK_W-1:0];
            REG_NAK_RETRIES:  cfg_retries = val[3:0];
            default: ;
        endcase
    endtask

    task automatic add_item(input logic [1:0] act, input logic [7:0] b,
                            input t_chk chk, input t_result want);
        t_dir_row row;
        row.kind = ROW_ITEM;
        row.sel  = act;
        row.val  = CFG_W'(b);
        row.chk  = chk;
        row.want = want;
        dir_rows.push_back(row);
    endtask

    task automatic add_cfg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        t_dir_row row;
        row.kind = ROW_CFG;
        row.sel  = idx;
        row.val  = val;
        row.chk  = CHK_NONE;
        row.want = '0;
        dir_rows.push_back(row);
    endtask

    // One transfer: noise, a silent sender, or blocks that are good or broken at one spot
    task automatic run_transfer();
        int         mode;
        int         nblk;
        int         bad_at;
        int         lim;
        logic [7:0] csum;
        logic [7:0] d;
        logic [7:0] frame[$];
        mode = $urandom_range(0, 9);
        if (mode == 1 && cfg_hs * (cfg_retries + 1) > 200)
            mode = 2;
        if (mode == 0) begin
            feed(ACT_TICK, 8'($urandom));
            feed(ACT_BYTE, 8'($urandom));
        end
        feed(ACT_START, 8'($urandom));
        if (mode == 0) begin
            repeat (10) feed(2'($urandom_range(0, 3)), 8'($urandom));
        end else if (mode == 1) begin
            repeat (cfg_hs * (cfg_retries + 1)) feed(ACT_TICK, 8'($urandom));
        end else begin
            // sometimes let one handshake wait run out so NAK is repeated
            if (cfg_retries != 0 && cfg_hs <= 20 && $urandom_range(0, 1) == 1)
                repeat (cfg_hs) feed(ACT_TICK, 8'($urandom));
            nblk = ($urandom_range(0, 3) == 0) ? 2 : 1;
            for (int k = 1; k <= nblk; k++) begin
                csum = 8'd0;
                frame.push_back(CH_SOH);
                frame.push_back(8'(k));
                frame.push_back(~8'(k));
                repeat (BLOCK_BYTES) begin
                    d = 8'($urandom);
                    csum = csum + d;
                    frame.push_back(d);
                end
                frame.push_back(csum);
            end
            frame.push_back(CH_EOT);
            bad_at = (mode >= 7) ? int'($urandom_range(0, frame.size() - 1)) : -1;
            foreach (frame[i]) begin
                lim = (i == 0) ? int'(cfg_hs) : int'(cfg_byte);
                if (lim > 1 && $urandom_range(0, 9) == 0)
                    repeat ($urandom_range(0, (lim > 3) ? 2 : lim - 1))
                        feed(ACT_TICK, 8'($urandom));
                if (i == bad_at && cfg_byte <= 50 && $urandom_range(0, 2) == 0)
                    repeat (cfg_byte) feed(ACT_TICK, 8'($urandom));
                else if (i == bad_at)
                    feed(ACT_BYTE, frame[i] ^ 8'($urandom_range(1, 255)));
                else
                    feed(ACT_BYTE, frame[i]);
                if (rx_ph == RX_IDLE) break;
            end
        end
        // bring the receiver back to idle with bytes it must reject
        while (rx_ph != RX_IDLE)
            feed(ACT_BYTE, (rx_ph == RX_SUM) ? ~rx_sum : 8'he7);
    endtask

    // Result side: random stalls
    always @(posedge clk) begin
        res_if.ready <= steady || ($urandom_range(0, 99) >= 6);
    end

    // Compare each result with the oldest expectation
    always @(posedge clk) begin
        t_result got;
        t_result want;
        if (rst_n && res_if.valid && res_if.ready) begin
            got.tx_valid   = res_if.tx_valid;
            got.tx_byte    = res_if.tx_byte;
            got.data_valid = res_if.data_valid;
            got.data_byte  = res_if.data_byte;
            got.status     = res_if.status;
            if (pending_out.size() == 0) begin
                if (errors < SHOWN_ERRORS)
                    $display("unexpected result: tx %0b/%02h data %0b/%02h status %0d",
                             got.tx_valid, got.tx_byte, got.data_valid, got.data_byte,
                             got.status);
                errors++;
            end else begin
                want = pending_out.pop_front();
                if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
                    got.data_valid !== want.data_valid ||
                    got.data_byte !== want.data_byte || got.status !== want.status) begin
                    if (errors < SHOWN_ERRORS)
                        $display("mismatch: want %0b/%02h %0b/%02h %0d got %0b/%02h %0b/%02h %0d",
                                 want.tx_valid, want.tx_byte, want.data_valid,
                                 want.data_byte, want.status, got.tx_valid, got.tx_byte,
                                 got.data_valid, got.data_byte, got.status);
                    errors++;
                end
            end
        end
    end

    initial begin
        logic [CFG_W-1:0] hs;
        logic [CFG_W-1:0] bt;
        logic [CFG_W-1:0] nr;
        int               start_at;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= REG_HS_TIMEOUT;
        cfg_data        <= '0;
        item_if.valid   <= 1'b0;
        item_if.action  <= ACT_BYTE;
        item_if.rx_byte <= 8'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Idle block ignores bytes, ticks and the unused action
        add_item(ACT_BYTE, CH_SOH, CHK_NONE, '0);
        add_item(ACT_TICK, 8'hff, CHK_NONE, '0);
        add_item(ACT_NONE, 8'hff, CHK_NONE, '0);
        // EOT is not accepted before a block
        add_item(ACT_START, 8'h00, CHK_GIVEN, ctl(CH_NAK, ST_RUN));
        add_item(ACT_BYTE, CH_EOT, CHK_GIVEN, ctl(CH_CAN, ST_ERROR));
        // Short timeouts, one retry: NAK repeats once, then no sender
        add_cfg(REG_HS_TIMEOUT, 20'd2);
        add_cfg(REG_BYTE_TIMEOUT, 20'd1);
        add_cfg(REG_NAK_RETRIES, 20'd1);
        add_item(ACT_START, 8'hff, CHK_GIVEN, ctl(CH_NAK, ST_RUN));
        add_item(ACT_TICK, 8'h00, CHK_NONE, '0);
        add_item(ACT_TICK, 8'h00, CHK_GIVEN, ctl(CH_NAK, ST_RUN));
        add_item(ACT_TICK, 8'h00, CHK_NONE, '0);
        add_item(ACT_TICK, 8'h00, CHK_GIVEN, ctl(CH_CAN, ST_NOSENDER));
        // Byte timeout after the sequence number
        add_item(ACT_START, 8'h00, CHK_GIVEN, ctl(CH_NAK, ST_RUN));
        add_item(ACT_BYTE, CH_SOH, CHK_MODEL, '0);
        add_item(ACT_BYTE, 8'h01, CHK_MODEL, '0);
        add_item(ACT_TICK, 8'h00, CHK_GIVEN, ctl(CH_CAN, ST_ERROR));
        // Restart while busy, then a wrong sequence number
        add_item(ACT_START, 8'h00, CHK_GIVEN, ctl(CH_NAK, ST_RUN));
        add_item(ACT_BYTE, CH_SOH, CHK_MODEL, '0);
        add_item(ACT_START, 8'h00, CHK_GIVEN, ctl(CH_NAK, ST_RUN));
        add_item(ACT_BYTE, CH_SOH, CHK_MODEL, '0);
        add_item(ACT_BYTE, 8'h02, CHK_GIVEN, ctl(CH_CAN, ST_ERROR));
        // Bad complement
        add_item(ACT_START, 8'h00, CHK_GIVEN, ctl(CH_NAK, ST_RUN));
        add_item(ACT_BYTE, CH_SOH, CHK_MODEL, '0);
        add_item(ACT_BYTE, 8'h01, CHK_MODEL, '0);
        add_item(ACT_BYTE, 8'hff, CHK_GIVEN, ctl(CH_CAN, ST_ERROR));
        // Zero timeout fires on the first tick; no retries
        add_cfg(REG_HS_TIMEOUT, 20'd0);
        add_cfg(REG_NAK_RETRIES, 20'd0);
        add_item(ACT_START, 8'h00, CHK_GIVEN, ctl(CH_NAK, ST_RUN));
        add_item(ACT_TICK, 8'h00, CHK_GIVEN, ctl(CH_CAN, ST_NOSENDER));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(dir_rows[i].sel, dir_rows[i].val);
            else
                send_item(dir_rows[i].sel, dir_rows[i].val[7:0], dir_rows[i].chk,
                          dir_rows[i].want);
        end

        // Random transfers under several settings, extremes first
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    hs = 20'd1;
                    bt = 20'd1;
                    nr = 20'd0;
                end
                1: begin
                    hs = 20'hfffff;
                    bt = 20'hfffff;
                    nr = 20'd15;
                end
                2: begin
                    hs = CFG_W'($urandom_range(1, 5));
                    bt = CFG_W'($urandom_range(1, 4));
                    nr = CFG_W'($urandom_range(0, 15));
                end
                default: begin
                    hs = CFG_W'($urandom_range(1, 8));
                    bt = CFG_W'($urandom_range(2, 12));
                    nr = CFG_W'($urandom_range(1, 4));
                end
            endcase
            write_reg(REG_HS_TIMEOUT, hs);
            write_reg(REG_BYTE_TIMEOUT, bt);
            write_reg(REG_NAK_RETRIES, nr);
            steady = (p == 2);
            start_at = live_items;
            while (live_items - start_at < PHASE_ITEMS) run_transfer();
        end
        steady = 1'b0;

        item_if.valid <= 1'b0;
        while (pending_out.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("tb_xmodem_checksum_receiver: done, clean");
        else
            $display("tb_xmodem_checksum_receiver: done, errors");
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("tb_xmodem_checksum_receiver: done, errors");
        $finish;
    end

endmodule

// ===== xmodem_checksum_receiver.f =====
rtl/xcr_pkg.sv
rtl/xcr_in_if.sv
rtl/xcr_out_if.sv
rtl/xcr_engine.sv
rtl/xmodem_checksum_receiver.sv
dv/tb_xmodem_checksum_receiver.sv
